/* design/pps_pkg.sv */
`default_nettype none

package pps_pkg;

    // Default depth of the ready list
    localparam int TASKS_DEF = 64;

    // Field widths
    localparam int ID_W     = 6;
    localparam int PRIO_W   = 8;
    localparam int REM_W    = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;

    // Command code of an arriving task (the other code is a tick)
    localparam logic CMD_ARRIVE = 1'b0;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 2'd0,
        ST_FULL   = 2'd1,
        ST_RAN    = 2'd2,
        ST_IDLE   = 2'd3
    } status_t;

    // One ready list entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [REM_W-1:0]  rem;
    } entry_t;

    // Read address source for the list memory
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_DOWN = 2'd1,
        RD_UP   = 2'd2
    } rd_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_in;
        logic    tick_time;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_entry;
        logic    ptr_dec;
        logic    ptr_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_full;
        logic    load_head;
        logic    out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_arrive;
        logic in_zero_burst;
        logic full;
        logic empty;
        logic ptr_zero;
        logic at_end;
        logic precedes;
        logic drop;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

/* design/pps_dp.sv */
`default_nettype none

module pps_dp #(
    parameter int TASKS = pps_pkg::TASKS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_command,
    input  wire logic [pps_pkg::ID_W-1:0]      s_task_id,
    input  wire logic [pps_pkg::PRIO_W-1:0]    s_priority_req,
    input  wire logic [pps_pkg::REM_W-1:0]     s_burst,
    input  wire pps_pkg::dp_cmd_t              cmd,
    output pps_pkg::dp_sts_t                   sts,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic [pps_pkg::STATUS_W-1:0]       m_status,
    output logic [pps_pkg::ID_W-1:0]           m_run_task,
    output logic                               m_task_done,
    output logic [pps_pkg::REM_W-1:0]          m_remaining_left,
    output logic [pps_pkg::TIME_W-1:0]         m_time_now
);
    import pps_pkg::*;

    localparam int IDX_W = $clog2(TASKS);
    localparam int CNT_W = $clog2(TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TASKS);

    entry_t              list_mem [TASKS];
    entry_t              mem_q_reg;
    entry_t              key_reg, key_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    status_t             res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_run_reg, res_run_next;
    logic                res_done_reg, res_done_next;
    logic [REM_W-1:0]    res_left_reg, res_left_next;
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [ID_W-1:0]     m_run_reg;
    logic                m_done_reg;
    logic [REM_W-1:0]    m_left_reg;
    logic [TIME_W-1:0]   m_time_reg;
    logic [CNT_W-1:0]    ptr_up;
    logic [IDX_W-1:0]    rd_addr;
    entry_t              wr_data;
    logic [REM_W-1:0]    head_rem;

    assign ptr_up   = CNT_W'(ptr_reg) + CNT_W'(1);
    assign head_rem = mem_q_reg.rem - REM_W'(1);
    assign wr_data  = cmd.wr_entry ? mem_q_reg : key_reg;

    // Pick the read address
    always_comb begin
        case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_DOWN: rd_addr = ptr_reg - IDX_W'(1);
            RD_UP:   rd_addr = ptr_up[IDX_W-1:0];
            default: rd_addr = '0;
        endcase
    end

    // Ready list memory, one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            list_mem[ptr_reg] <= wr_data;
        end
        if (cmd.rd_en) begin
            mem_q_reg <= list_mem[rd_addr];
        end
    end

    // Report status to the controller
    always_comb begin
        sts.in_arrive     = (s_command == CMD_ARRIVE);
        sts.in_zero_burst = (s_burst == '0);
        sts.full          = (cnt_reg == CNT_FULL);
        sts.empty         = (cnt_reg == '0);
        sts.ptr_zero      = (ptr_reg == '0);
        sts.at_end        = (ptr_up == cnt_reg);
        sts.precedes      = (mem_q_reg.prio < key_reg.prio) ||
                            ((mem_q_reg.prio == key_reg.prio) &&
                             (mem_q_reg.rem <= key_reg.rem));
        sts.drop          = (key_reg.rem == '0);
        sts.out_free      = !m_valid_reg || m_ready;
    end

    // Next values of the walk pointer, key, count and clock
    always_comb begin
        ptr_next  = ptr_reg;
        key_next  = key_reg;
        cnt_next  = cnt_reg;
        time_next = time_reg;
        if (cmd.load_in) begin
            ptr_next = cnt_reg[IDX_W-1:0];
            key_next = '{id: s_task_id, prio: s_priority_req, rem: s_burst};
        end
        if (cmd.load_head) begin
            ptr_next = '0;
            key_next = '{id: mem_q_reg.id, prio: mem_q_reg.prio, rem: head_rem};
        end
        if (cmd.ptr_dec) begin
            ptr_next = ptr_reg - IDX_W'(1);
        end
        if (cmd.ptr_inc) begin
            ptr_next = ptr_up[IDX_W-1:0];
        end
        if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (cmd.tick_time) begin
            time_next = time_reg + TIME_W'(1);
        end
    end

    // Build the result of the current item
    always_comb begin
        res_status_next = res_status_reg;
        res_run_next    = res_run_reg;
        res_done_next   = res_done_reg;
        res_left_next   = res_left_reg;
        if (cmd.load_in) begin
            res_status_next = sts.in_arrive ? ST_ACCEPT : ST_IDLE;
            res_run_next    = sts.in_arrive ? s_task_id : '0;
            res_done_next   = 1'b0;
            res_left_next   = '0;
        end
        if (cmd.set_full) begin
            res_status_next = ST_FULL;
        end
        if (cmd.load_head) begin
            res_status_next = ST_RAN;
            res_run_next    = mem_q_reg.id;
            res_done_next   = (head_rem == '0);
            res_left_next   = head_rem;
        end
    end

    // Hold working payload
    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_run_reg    <= res_run_next;
        res_done_reg   <= res_done_next;
        res_left_reg   <= res_left_next;
    end

    // Control state: fill count and time counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            time_reg <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            time_reg <= time_next;
        end
    end

    // Output register: load a finished item, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_run_reg    <= res_run_reg;
            m_done_reg   <= res_done_reg;
            m_left_reg   <= res_left_reg;
            m_time_reg   <= time_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_run_task       = m_run_reg;
    assign m_task_done      = m_done_reg;
    assign m_remaining_left = m_left_reg;
    assign m_time_now       = m_time_reg;

endmodule

`default_nettype wire

/* design/pps_ctrl.sv */
`default_nettype none

module pps_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output pps_pkg::dp_cmd_t      cmd,
    input  wire pps_pkg::dp_sts_t sts
);
    import pps_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_A_CHK  = 7'b0000010,
        S_A_CMP  = 7'b0000100,
        S_T_HEAD = 7'b0001000,
        S_T_CHK  = 7'b0010000,
        S_T_CMP  = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Sequence the insert walk and the tick walk
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_ZERO;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    if (sts.in_arrive) begin
                        if (sts.in_zero_burst) begin
                            state_next = S_FIN;
                        end else if (sts.full) begin
                            cmd.set_full = 1'b1;
                            state_next   = S_FIN;
                        end else begin
                            state_next = S_A_CHK;
                        end
                    end else begin
                        cmd.tick_time = 1'b1;
                        if (sts.empty) begin
                            state_next = S_FIN;
                        end else begin
                            // fetch the head entry
                            cmd.rd_en  = 1'b1;
                            state_next = S_T_HEAD;
                        end
                    end
                end
            end
            S_A_CHK: begin
                if (sts.ptr_zero) begin
                    cmd.wr_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DOWN;
                    state_next = S_A_CMP;
                end
            end
            S_A_CMP: begin
                if (sts.precedes) begin
                    cmd.wr_en   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end else begin
                    // shift the entry up one slot
                    cmd.wr_en    = 1'b1;
                    cmd.wr_entry = 1'b1;
                    cmd.ptr_dec  = 1'b1;
                    state_next   = S_A_CHK;
                end
            end
            S_T_HEAD: begin
                cmd.load_head = 1'b1;
                state_next    = S_T_CHK;
            end
            S_T_CHK: begin
                if (sts.at_end) begin
                    if (sts.drop) begin
                        cmd.cnt_dec = 1'b1;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                    state_next = S_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP;
                    state_next = S_T_CMP;
                end
            end
            S_T_CMP: begin
                if (!sts.drop && !sts.precedes) begin
                    cmd.wr_en  = 1'b1;
                    state_next = S_FIN;
                end else begin
                    // shift the entry down one slot
                    cmd.wr_en    = 1'b1;
                    cmd.wr_entry = 1'b1;
                    cmd.ptr_inc  = 1'b1;
                    state_next   = S_T_CHK;
                end
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* design/preemptive_priority_sjf_scheduler.sv */
// Preemptive priority scheduler with shortest-remaining tie-break.
// Input channel (s_valid/s_ready): command 0 inserts task s_task_id with
// s_priority_req and s_burst into the ordered ready list; command 1 is a
// time tick that runs the head task for one unit and reinserts it if
// time is left. Result channel (m_valid/m_ready): one item per input item
// with status, run_task, task_done, remaining_left and time_now.
// One item is worked on at a time. The list sits in a memory with one
// write port and one registered read port, and the walk reads and then
// writes each entry moved or compared. An arrival walks from the end of
// the list toward its slot, passing the entries behind that slot; a tick
// walks from the head toward the end of the list.
// Zero-burst arrivals, refused arrivals and ticks on an empty list go
// straight to the result.
// Reset empties the list (fill count to zero) and clears the time
// counter; no clearing pass is needed. A finished result waits in the
// output register while m_ready is low; the next item is taken as soon
// as its walk starts, and it finishes only once that register is free.
`default_nettype none

module preemptive_priority_sjf_scheduler #(
    parameter int TASKS = pps_pkg::TASKS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_command,
    input  wire logic [pps_pkg::ID_W-1:0]   s_task_id,
    input  wire logic [pps_pkg::PRIO_W-1:0] s_priority_req,
    input  wire logic [pps_pkg::REM_W-1:0]  s_burst,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [pps_pkg::STATUS_W-1:0]    m_status,
    output logic [pps_pkg::ID_W-1:0]        m_run_task,
    output logic                            m_task_done,
    output logic [pps_pkg::REM_W-1:0]       m_remaining_left,
    output logic [pps_pkg::TIME_W-1:0]      m_time_now
);
    import pps_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    pps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    pps_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_command        (s_command),
        .s_task_id        (s_task_id),
        .s_priority_req   (s_priority_req),
        .s_burst          (s_burst),
        .cmd              (cmd),
        .sts              (sts),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_status         (m_status),
        .m_run_task       (m_run_task),
        .m_task_done      (m_task_done),
        .m_remaining_left (m_remaining_left),
        .m_time_now       (m_time_now)
    );

`ifndef SYNTHESIS
    // Never grow a full list
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.full && cmd.cnt_inc))
        else $error("ready list grown past its depth");

    // One item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in work");

    // A run result flags completion exactly when no time is left
    a_done_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_RAN)) |-> (m_task_done == (m_remaining_left == '0)))
        else $error("task_done disagrees with remaining_left");

    // An idle tick carries no task
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_IDLE)) |->
        ((m_run_task == '0) && !m_task_done && (m_remaining_left == '0)))
        else $error("idle result carries task fields");
`endif

endmodule

`default_nettype wire

/* tb/preemptive_priority_sjf_scheduler_tb.sv */
`default_nettype none

module preemptive_priority_sjf_scheduler_tb;

    import pps_pkg::*;

    localparam int   DEPTH      = TASKS_DEF;
    localparam logic CMD_TICK   = ~CMD_ARRIVE;
    localparam int   ITEMS      = 800;
    localparam int   HOLD_AT    = 200;   // results seen before the long receiver stall
    localparam int   HOLD_LEN   = 400;   // length of that stall in cycles
    localparam int   STALL_LIMIT = 4000; // cycles with no handshake before giving up
    localparam int   SETTLE     = 160;   // quiet cycles after the last result

    // One input item, plus a flag that makes the sender wait for all results
    typedef struct {
        logic              command;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [REM_W-1:0]  burst;
        bit                drain;
    } job_t;

    // One result item
    typedef struct {
        status_t           status;
        logic [ID_W-1:0]   run_task;
        logic              done;
        logic [REM_W-1:0]  left;
        logic [TIME_W-1:0] now;
    } outcome_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_command      = CMD_TICK;
    logic [ID_W-1:0]     s_task_id      = '0;
    logic [PRIO_W-1:0]   s_priority_req = '0;
    logic [REM_W-1:0]    s_burst        = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ID_W-1:0]     m_run_task;
    logic                m_task_done;
    logic [REM_W-1:0]    m_remaining_left;
    logic [TIME_W-1:0]   m_time_now;

    // Scheduler model state
    entry_t            sched_list[$];
    logic [TIME_W-1:0] sched_time = '0;

    job_t     stim_q[$];
    outcome_t due_q[$];
    job_t     drv_cur;
    job_t     drv_next;
    bit       drv_took;
    int       drv_gap  = 0;
    int       sent_cnt = 0;
    int       got_cnt  = 0;
    int       rdy_gap  = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    outcome_t mon_want;
    int       err_count = 0;
    int       stall_cycles = 0;
    bit       timed_out = 1'b0;
    int       total_items = ITEMS;

    preemptive_priority_sjf_scheduler #(
        .TASKS(DEPTH)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_task_id        (s_task_id),
        .s_priority_req   (s_priority_req),
        .s_burst          (s_burst),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_run_task       (m_run_task),
        .m_task_done      (m_task_done),
        .m_remaining_left (m_remaining_left),
        .m_time_now       (m_time_now)
    );

    // Place a task behind every entry that is more urgent, or equally urgent
    // with no more time left
    function automatic void list_place(entry_t e);
        int pos;
        pos = 0;
        while (pos < sched_list.size()) begin
            if (sched_list[pos].prio > e.prio) break;
            if (sched_list[pos].prio == e.prio && sched_list[pos].rem > e.rem) break;
            pos++;
        end
        sched_list.insert(pos, e);
    endfunction

    // Advance the scheduler model by one item and return its result
    function automatic outcome_t schedule_step(job_t j);
        outcome_t r;
        entry_t   head;
        r.status   = ST_ACCEPT;
        r.run_task = '0;
        r.done     = 1'b0;
        r.left     = '0;
        if (j.command == CMD_ARRIVE) begin
            r.run_task = j.id;
            if (j.burst == '0) begin
                r.status = ST_ACCEPT;
            end else if (sched_list.size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                head.id   = j.id;
                head.prio = j.prio;
                head.rem  = j.burst;
                list_place(head);
                r.status = ST_ACCEPT;
            end
        end else begin
            sched_time = sched_time + 1'b1;
            if (sched_list.size() == 0) begin
                r.status = ST_IDLE;
            end else begin
                head = sched_list.pop_front();
                head.rem = head.rem - 1'b1;
                r.status   = ST_RAN;
                r.run_task = head.id;
                r.left     = head.rem;
                if (head.rem == '0) begin
                    r.done = 1'b1;
                end else begin
                    list_place(head);
                end
            end
        end
        r.now = sched_time;
        return r;
    endfunction

    function automatic job_t job(logic cmd, int id, int prio, int burst, bit drain = 1'b0);
        job_t j;
        j.command = cmd;
        j.id      = ID_W'(id);
        j.prio    = PRIO_W'(prio);
        j.burst   = REM_W'(burst);
        j.drain   = drain;
        return j;
    endfunction

    // Mostly short bursts so tasks finish; now and then zero or very long ones
    function automatic int rand_burst();
        int pick;
        pick = $urandom_range(0, 63);
        if (pick < 2) return 0;
        if (pick == 2) return 16'hFFFF;
        if (pick == 3) return $urandom_range(0, 65535);
        if (pick < 10) return $urandom_range(7, 40);
        return $urandom_range(1, 6);
    endfunction

    // Few priorities most of the time, so ties are common
    function automatic int rand_prio();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 255);
            1:       return ($urandom_range(0, 1) != 0) ? 255 : 0;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic int rand_id();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 63);
    endfunction

    function automatic bit sender_may_idle(int done_cnt);
        return ((done_cnt / 100) % 3 != 2) && (total_items - done_cnt > 80);
    endfunction

    // Clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Build the stimulus, release reset, then wait for the run to finish
    initial begin
        int seg_len;
        int arrive_pct;
        int k;

        // Directed: empty tick, zero burst, field extremes, ties, duplicates
        stim_q.push_back(job(CMD_TICK, 0, 0, 0));
        stim_q.push_back(job(CMD_ARRIVE, 0, 0, 0));
        stim_q.push_back(job(CMD_ARRIVE, 63, 255, 16'hFFFF));
        stim_q.push_back(job(CMD_ARRIVE, 1, 0, 1));
        stim_q.push_back(job(CMD_TICK, 63, 255, 16'hFFFF));
        stim_q.push_back(job(CMD_ARRIVE, 2, 7, 3));
        stim_q.push_back(job(CMD_ARRIVE, 3, 7, 2));
        stim_q.push_back(job(CMD_ARRIVE, 4, 7, 2));
        stim_q.push_back(job(CMD_ARRIVE, 2, 7, 3));
        stim_q.push_back(job(CMD_ARRIVE, 6'h2A, 8'hAA, 16'hAAAA));
        stim_q.push_back(job(CMD_ARRIVE, 6'h15, 8'h55, 16'h5555));
        stim_q.push_back(job(CMD_ARRIVE, 5, 6, 1));
        for (k = 0; k < 12; k++) begin
            stim_q.push_back(job(CMD_TICK, $urandom_range(0, 63), $urandom_range(0, 255),
                                 $urandom_range(0, 65535)));
        end

        // Fill the list past its depth after a full drain, then work it down
        stim_q.push_back(job(CMD_ARRIVE, rand_id(), $urandom_range(0, 15),
                             $urandom_range(1, 4), 1'b1));
        for (k = 1; k < DEPTH + 6; k++) begin
            stim_q.push_back(job(CMD_ARRIVE, rand_id(), $urandom_range(0, 15),
                                 $urandom_range(1, 4)));
        end
        for (k = 0; k < DEPTH + 6; k++) begin
            stim_q.push_back(job(CMD_TICK, rand_id(), rand_prio(), rand_burst()));
        end
        stim_q.push_back(job(CMD_TICK, 0, 0, 0, 1'b1));

        // Random segments with a varying share of arrivals
        while (stim_q.size() < ITEMS) begin
            seg_len = $urandom_range(40, 80);
            case ($urandom_range(0, 2))
                0:       arrive_pct = 25;
                1:       arrive_pct = 45;
                default: arrive_pct = 65;
            endcase
            for (k = 0; k < seg_len && stim_q.size() < ITEMS; k++) begin
                if ($urandom_range(0, 99) < arrive_pct) begin
                    stim_q.push_back(job(CMD_ARRIVE, rand_id(), rand_prio(), rand_burst()));
                end else begin
                    stim_q.push_back(job(CMD_TICK, rand_id(), rand_prio(), rand_burst()));
                end
            end
        end
        total_items = stim_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (!timed_out && !(stim_q.size() == 0 && !s_valid && got_cnt == sent_cnt))
            @(posedge aclk);
        for (k = 0; k < SETTLE && !timed_out; k++)
            @(posedge aclk);

        if (timed_out) begin
            $display("preemptive_priority_sjf_scheduler_tb: errors");
        end else if (err_count == 0 && due_q.size() == 0) begin
            $display("preemptive_priority_sjf_scheduler_tb: clean");
        end else begin
            $display("preemptive_priority_sjf_scheduler_tb: errors");
        end
        $finish;
    end

    // Driver: offer queued items, idle in bursts, hold for drains
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drv_gap <= 0;
        end else begin
            drv_took = s_valid && s_ready;
            if (drv_took) begin
                due_q.push_back(schedule_step(drv_cur));
                sent_cnt <= sent_cnt + 1;
            end
            if (s_valid && !s_ready) begin
                // hold the item until it is taken
            end else if (drv_gap > 0) begin
                s_valid <= 1'b0;
                drv_gap <= drv_gap - 1;
            end else if (stim_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (stim_q[0].drain && (sent_cnt + int'(drv_took) != got_cnt)) begin
                s_valid <= 1'b0;
            end else if (sender_may_idle(sent_cnt) && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                drv_gap <= $urandom_range(1, 11) - 1;
            end else begin
                drv_next = stim_q.pop_front();
                drv_cur  = drv_next;
                s_valid        <= 1'b1;
                s_command      <= drv_next.command;
                s_task_id      <= drv_next.id;
                s_priority_req <= drv_next.prio;
                s_burst        <= drv_next.burst;
            end
        end
    end

    // Monitor: check each result against the oldest one due, pace m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rdy_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got_cnt <= got_cnt + 1;
                if (due_q.size() == 0) begin
                    $error("unexpected result: status %0d run_task %0d", m_status, m_run_task);
                    err_count++;
                end else begin
                    mon_want = due_q.pop_front();
                    if (m_status !== mon_want.status) begin
                        $error("status: expected %0d, got %0d", mon_want.status, m_status);
                        err_count++;
                    end
                    if (m_run_task !== mon_want.run_task) begin
                        $error("run_task: expected %0d, got %0d",
                               mon_want.run_task, m_run_task);
                        err_count++;
                    end
                    if (m_task_done !== mon_want.done) begin
                        $error("task_done: expected %0d, got %0d", mon_want.done, m_task_done);
                        err_count++;
                    end
                    if (m_remaining_left !== mon_want.left) begin
                        $error("remaining_left: expected %0d, got %0d",
                               mon_want.left, m_remaining_left);
                        err_count++;
                    end
                    if (m_time_now !== mon_want.now) begin
                        $error("time_now: expected %0d, got %0d", mon_want.now, m_time_now);
                        err_count++;
                    end
                end
            end
            // One long stall so the block backs up, otherwise short random ones
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && got_cnt >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN - 1;
                m_ready   <= 1'b0;
            end else if (rdy_gap > 0) begin
                m_ready <= 1'b0;
                rdy_gap <= rdy_gap - 1;
            end else if (sender_may_idle(got_cnt + 50) && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                rdy_gap <= $urandom_range(1, 11) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: flag a run in which no item moves for too long; a result that
    // nobody is waiting for does not count as movement
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) ||
            (m_valid && m_ready && (got_cnt < sent_cnt))) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            timed_out <= 1'b1;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

`default_nettype wire
